// ----- rtl/nmpp_pkg.sv -----
`default_nettype none

package nmpp_pkg;

	// Characters the parser reacts to
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_W     = 8'h57;

	localparam int unsigned HDR_LEN = 6;
	localparam int unsigned NUM_HDR = 6;
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_GGA = 2'd0,
		KIND_RMC = 2'd1,
		KIND_GLL = 2'd2
	} kind_t;

	typedef enum logic {
		TALK_GP = 1'b0,
		TALK_GN = 1'b1
	} talker_t;

	typedef enum logic [1:0] {
		FLD_LAT     = 2'd0,
		FLD_LAT_DIR = 2'd1,
		FLD_LON     = 2'd2,
		FLD_LON_DIR = 2'd3
	} fld_role_t;

	typedef struct packed {
		talker_t talker;
		kind_t   kind;
	} hdr_t;

	// Candidate headers, ordered talker * 3 + kind
	localparam logic [7:0] HDR_TEXT [NUM_HDR][HDR_LEN] = '{
		'{"$", "G", "P", "G", "G", "A"},
		'{"$", "G", "P", "R", "M", "C"},
		'{"$", "G", "P", "G", "L", "L"},
		'{"$", "G", "N", "G", "G", "A"},
		'{"$", "G", "N", "R", "M", "C"},
		'{"$", "G", "N", "G", "L", "L"}
	};
	localparam kind_t HDR_KIND [NUM_HDR] = '{
		KIND_GGA, KIND_RMC, KIND_GLL, KIND_GGA, KIND_RMC, KIND_GLL
	};
	localparam talker_t HDR_TALKER [NUM_HDR] = '{
		TALK_GP, TALK_GP, TALK_GP, TALK_GN, TALK_GN, TALK_GN
	};

	// Constant reciprocals for the divide-by-constant steps (floor of 2^32 / n)
	localparam logic [25:0] RECIP_100 = 26'd42949672;
	localparam logic [28:0] RECIP_15  = 29'd286331153;
	localparam logic [23:0] E7        = 24'd10000000;

	// Powers of ten up to 10^7
	function automatic logic [23:0] pow10(input logic [2:0] e);
		logic [23:0] p;
		unique case (e)
			3'd0: p = 24'd1;
			3'd1: p = 24'd10;
			3'd2: p = 24'd100;
			3'd3: p = 24'd1000;
			3'd4: p = 24'd10000;
			3'd5: p = 24'd100000;
			3'd6: p = 24'd1000000;
			3'd7: p = 24'd10000000;
		endcase
		return p;
	endfunction

	// Field index of a coordinate part for each sentence kind
	function automatic logic [3:0] fld_idx(input kind_t kind, input fld_role_t role);
		logic [3:0] base;
		unique case (kind)
			KIND_GGA: base = 4'd2;
			KIND_RMC: base = 4'd3;
			KIND_GLL: base = 4'd1;
			default:  base = 4'd1;
		endcase
		return base + 4'(role);
	endfunction

	// Lowest surviving candidate decides the header
	function automatic hdr_t decode_hdr(input logic [NUM_HDR-1:0] m);
		hdr_t h;
		h.talker = TALK_GP;
		h.kind   = KIND_GGA;
		for (int k = NUM_HDR - 1; k >= 0; k--) begin
			if (m[k]) begin
				h.talker = HDR_TALKER[k];
				h.kind   = HDR_KIND[k];
			end
		end
		return h;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/nmpp_if.sv -----
`default_nettype none

// Byte stream channel
interface nmpp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// Position result channel
interface nmpp_pos_if;
	logic               valid;
	logic               ready;
	logic signed [34:0] latitude_e7;
	logic signed [34:0] longitude_e7;
	logic [1:0]         sentence_kind;
	logic               talker_kind;

	modport source (output valid, output latitude_e7, output longitude_e7,
		output sentence_kind, output talker_kind, input ready);
	modport sink (input valid, input latitude_e7, input longitude_e7,
		input sentence_kind, input talker_kind, output ready);
endinterface

`default_nettype wire

// ----- rtl/nmea_position_parser.sv -----
`default_nettype none

// NMEA 0183 position parser. Takes one received character per cycle on byte_in
// and gives one position record on pos_out for each $GPGGA/$GNGGA/$GPRMC/
// $GNRMC/$GPGLL/$GNGLL line that reaches its longitude direction field.
// Every cycle a byte can be taken: the line parser in front handles each
// byte in the cycle it arrives, and only stalls if the four-entry record
// queue is full. Behind the queue a six-stage conversion pipeline turns the
// captured ddmm.mmmm numbers into signed degrees in 1e-7 units, using
// constant-reciprocal multiplies for the divides by 100 and 60, and issues
// one record per cycle while pos_out is ready. A record reaches pos_out
// through the queue and then stages 1 to 6. No checksum is checked. No memory,
// no clearing pass after reset.
module nmea_position_parser
	import nmpp_pkg::*;
#(
	parameter int unsigned FRACTION_DIGITS = 5,
	parameter int unsigned INTEGER_LIMIT = 99999
) (
	input  wire        clk,
	input  wire        arst_n,
	nmpp_byte_if.sink  byte_in,
	nmpp_pos_if.source pos_out
);

	localparam int unsigned IW = $clog2(INTEGER_LIMIT + 1);
	localparam int unsigned FW = $clog2(pow10(3'(FRACTION_DIGITS)));
	localparam int unsigned NW = $clog2(FRACTION_DIGITS + 1);
	localparam int unsigned RW = 2 * (IW + FW + NW + 1) + 3;

	logic          fr_valid, fr_ready;
	logic [RW-1:0] fr_data;
	logic          bk_valid, bk_ready;
	logic [RW-1:0] bk_data;

	// Line parser: header match, field counting, digit capture
	nmpp_front #(
		.FRACTION_DIGITS(FRACTION_DIGITS),
		.INTEGER_LIMIT(INTEGER_LIMIT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_in),
		.rec_valid(fr_valid),
		.rec_ready(fr_ready),
		.rec_data(fr_data)
	);

	// Record queue between parser and converter
	nmpp_fifo #(
		.WIDTH(RW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(fr_valid),
		.push_ready(fr_ready),
		.push_data(fr_data),
		.pop_valid(bk_valid),
		.pop_ready(bk_ready),
		.pop_data(bk_data)
	);

	// Conversion pipeline
	nmpp_conv #(
		.FRACTION_DIGITS(FRACTION_DIGITS),
		.INTEGER_LIMIT(INTEGER_LIMIT)
	) u_conv (
		.clk(clk),
		.arst_n(arst_n),
		.rec_valid(bk_valid),
		.rec_ready(bk_ready),
		.rec_data(bk_data),
		.pos_out(pos_out)
	);

endmodule

`default_nettype wire

// ----- rtl/nmpp_front.sv -----
`default_nettype none

module nmpp_front
	import nmpp_pkg::*;
#(
	parameter int unsigned FRACTION_DIGITS = 5,
	parameter int unsigned INTEGER_LIMIT = 99999,
	localparam int unsigned IW = $clog2(INTEGER_LIMIT + 1),
	localparam int unsigned FW = $clog2(pow10(3'(FRACTION_DIGITS))),
	localparam int unsigned NW = $clog2(FRACTION_DIGITS + 1),
	localparam int unsigned CW = IW + FW + NW + 1,
	localparam int unsigned RW = 2 * CW + 3
) (
	input  wire           clk,
	input  wire           arst_n,
	nmpp_byte_if.sink     byte_in,
	output logic          rec_valid,
	input  wire           rec_ready,
	output logic [RW-1:0] rec_data
);

	logic [2:0]         pos_q, pos_n;
	logic [NUM_HDR-1:0] match_q, match_n, hm;
	logic               rej_q, rej_n;
	logic [3:0]         fidx_q, fidx_n;
	logic               bac_q, bac_n;
	logic [IW-1:0]      int_q [2];
	logic [IW-1:0]      int_n [2];
	logic [FW-1:0]      frac_q [2];
	logic [FW-1:0]      frac_n [2];
	logic [NW-1:0]      cnt_q [2];
	logic [NW-1:0]      cnt_n [2];
	logic [1:0]         dot_q, dot_n, stop_q, stop_n, neg_q, neg_n;

	logic [7:0]      c;
	logic            acc, is_lf, is_digit, emit;
	logic [3:0]      digit;
	hdr_t            hdr;
	logic [3:0]      num_sel [2];
	logic [3:0]      dir_sel [2];
	logic [3:0]      lon_dir;
	logic [IW+3:0]   int_acc [2];
	logic [FW+3:0]   frac_acc [2];

	assign c        = byte_in.data_byte;
	assign acc      = byte_in.valid && byte_in.ready;
	assign is_lf    = (c == CH_LF);
	assign is_digit = (c >= CH_0) && (c <= CH_9);
	assign digit    = 4'(c - CH_0);
	assign byte_in.ready = rec_ready;

	// Decode header and pick field indexes for this sentence
	assign hdr        = decode_hdr(match_q);
	assign num_sel[0] = fld_idx(hdr.kind, FLD_LAT);
	assign dir_sel[0] = fld_idx(hdr.kind, FLD_LAT_DIR);
	assign num_sel[1] = fld_idx(hdr.kind, FLD_LON);
	assign dir_sel[1] = fld_idx(hdr.kind, FLD_LON_DIR);
	assign lon_dir    = dir_sel[1];

	// Emit a record at newline once the longitude direction field was reached
	assign emit = !rej_q && (pos_q == 3'(HDR_LEN)) &&
		((fidx_q > lon_dir) || ((fidx_q == lon_dir) && bac_q));
	assign rec_valid = acc && is_lf && emit;

	always_comb begin
		rec_data[2*CW +: 2] = hdr.kind;
		rec_data[2*CW + 2]  = hdr.talker;
		for (int l = 0; l < 2; l++) begin
			rec_data[l*CW +: IW]          = int_q[l];
			rec_data[l*CW + IW +: FW]     = frac_q[l];
			rec_data[l*CW + IW + FW +: NW] = cnt_q[l];
			rec_data[l*CW + IW + FW + NW] = neg_q[l];
		end
	end

	// Header comparison against every candidate at the current position
	always_comb begin
		for (int k = 0; k < NUM_HDR; k++) begin
			hm[k] = (HDR_TEXT[k][pos_q] == c);
		end
	end

	// Digit accumulation for both coordinates
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			int_acc[l]  = (IW+4)'(int_q[l]) * (IW+4)'(10) + (IW+4)'(digit);
			frac_acc[l] = (FW+4)'(frac_q[l]) * (FW+4)'(10) + (FW+4)'(digit);
		end
	end

	// Next line state
	always_comb begin
		pos_n   = pos_q;
		match_n = match_q;
		rej_n   = rej_q;
		fidx_n  = fidx_q;
		bac_n   = bac_q;
		dot_n   = dot_q;
		stop_n  = stop_q;
		neg_n   = neg_q;
		for (int l = 0; l < 2; l++) begin
			int_n[l]  = int_q[l];
			frac_n[l] = frac_q[l];
			cnt_n[l]  = cnt_q[l];
		end
		if (acc) begin
			if (is_lf) begin
				// clear everything for the next line
				pos_n   = '0;
				match_n = '1;
				rej_n   = 1'b0;
				fidx_n  = '0;
				bac_n   = 1'b0;
				dot_n   = '0;
				stop_n  = '0;
				neg_n   = '0;
				for (int l = 0; l < 2; l++) begin
					int_n[l]  = '0;
					frac_n[l] = '0;
					cnt_n[l]  = '0;
				end
			end else if (!rej_q) begin
				if (pos_q < 3'(HDR_LEN)) begin
					match_n = match_q & hm;
					pos_n   = pos_q + 3'd1;
					if ((match_q & hm) == '0) begin
						rej_n = 1'b1;
					end
					bac_n = 1'b1;
				end else if (c == CH_COMMA) begin
					if (fidx_q != 4'hF) begin
						fidx_n = fidx_q + 4'd1;
					end
					bac_n = 1'b0;
				end else begin
					for (int l = 0; l < 2; l++) begin
						if (fidx_q == num_sel[l]) begin
							if (!stop_q[l]) begin
								if (is_digit) begin
									if (dot_q[l]) begin
										if (cnt_q[l] < NW'(FRACTION_DIGITS)) begin
											frac_n[l] = FW'(frac_acc[l]);
											cnt_n[l]  = cnt_q[l] + NW'(1);
										end
									end else if (int_acc[l] > (IW+4)'(INTEGER_LIMIT)) begin
										int_n[l] = IW'(INTEGER_LIMIT);
									end else begin
										int_n[l] = IW'(int_acc[l]);
									end
								end else if ((c == CH_DOT) && !dot_q[l]) begin
									dot_n[l] = 1'b1;
								end else begin
									stop_n[l] = 1'b1;
								end
							end
						end else if ((fidx_q == dir_sel[l]) && !bac_q) begin
							neg_n[l] = (c == CH_S) || (c == CH_W);
						end
					end
					bac_n = 1'b1;
				end
			end
		end
	end

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			match_q <= '1;
			rej_q   <= 1'b0;
			fidx_q  <= '0;
			bac_q   <= 1'b0;
			dot_q   <= '0;
			stop_q  <= '0;
			neg_q   <= '0;
			for (int l = 0; l < 2; l++) begin
				int_q[l]  <= '0;
				frac_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else begin
			pos_q   <= pos_n;
			match_q <= match_n;
			rej_q   <= rej_n;
			fidx_q  <= fidx_n;
			bac_q   <= bac_n;
			dot_q   <= dot_n;
			stop_q  <= stop_n;
			neg_q   <= neg_n;
			for (int l = 0; l < 2; l++) begin
				int_q[l]  <= int_n[l];
				frac_q[l] <= frac_n[l];
				cnt_q[l]  <= cnt_n[l];
			end
		end
	end

	a_newline_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && is_lf |=> (pos_q == 3'd0) && !rej_q && (fidx_q == 4'd0) && !bac_q)
		else $error("line state not cleared after newline");

	a_live_header: assert property (@(posedge clk) disable iff (!arst_n)
		!rej_q |-> (match_q != '0))
		else $error("header accepted with no surviving candidate");

	a_frac_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= NW'(FRACTION_DIGITS)) && (cnt_q[1] <= NW'(FRACTION_DIGITS)))
		else $error("fraction digit count beyond limit");

endmodule

`default_nettype wire

// ----- rtl/nmpp_fifo.sv -----
`default_nettype none

// Register queue; DEPTH is a power of two so the pointers wrap by themselves
module nmpp_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4,
	localparam int unsigned AW = $clog2(DEPTH),
	localparam int unsigned NW = $clog2(DEPTH + 1)
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	output logic             push_ready,
	input  wire  [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  wire              pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [NW-1:0]    cnt_q;
	logic             push, pop;

	assign push_ready = (cnt_q != NW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(DEPTH))
		else $error("queue fill count beyond depth");

	a_cnt_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + NW'(1))
		else $error("queue count missed a push");

	a_pop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && !pop_ready |=> pop_valid && $stable(pop_data))
		else $error("queue head changed while waiting");

endmodule

`default_nettype wire

// ----- rtl/nmpp_conv.sv -----
`default_nettype none

// Six-stage conversion of ddmm.mmmm records into signed 1e-7 degrees
module nmpp_conv
	import nmpp_pkg::*;
#(
	parameter int unsigned FRACTION_DIGITS = 5,
	parameter int unsigned INTEGER_LIMIT = 99999,
	localparam int unsigned IW = $clog2(INTEGER_LIMIT + 1),
	localparam int unsigned FW = $clog2(pow10(3'(FRACTION_DIGITS))),
	localparam int unsigned NW = $clog2(FRACTION_DIGITS + 1),
	localparam int unsigned CW = IW + FW + NW + 1,
	localparam int unsigned RW = 2 * CW + 3
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           rec_valid,
	output logic          rec_ready,
	input  wire  [RW-1:0] rec_data,
	nmpp_pos_if.source    pos_out
);

	localparam int unsigned QW   = IW - 6;
	localparam int unsigned DPW  = QW + 24;
	localparam int unsigned SUMW = (DPW + 1 > 35) ? DPW + 1 : 35;
	localparam logic [23:0] SHIFT_SCALE = pow10(3'(7 - FRACTION_DIGITS));

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	logic [1:0] kind_s1, kind_s2, kind_s3, kind_s4, kind_s5, kind_s6;
	logic       talk_s1, talk_s2, talk_s3, talk_s4, talk_s5, talk_s6;
	logic [1:0] neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;

	logic [IW-1:0]    int_in [2];
	logic [FW-1:0]    frac_in [2];
	logic [NW-1:0]    cnt_in [2];
	logic [IW+25:0]   prod100 [2];
	logic [FW+23:0]   prodfs [2];
	logic [7:0]       rem100 [2];
	logic [56:0]      prod15 [2];
	logic [4:0]       rem15 [2];
	logic [SUMW-1:0]  sum [2];

	logic [IW-1:0]   int_s1 [2];
	logic [QW-1:0]   q100_s1 [2];
	logic [FW-1:0]   fs_s1 [2];
	logic [QW-1:0]   deg_s2 [2];
	logic [6:0]      mm_s2 [2];
	logic [FW-1:0]   fs_s2 [2];
	logic [29:0]     min_s3 [2];
	logic [DPW-1:0]  degp_s3 [2];
	logic [27:0]     x_s4 [2];
	logic [23:0]     q15_s4 [2];
	logic [DPW-1:0]  degp_s4 [2];
	logic [23:0]     q15_s5 [2];
	logic [DPW-1:0]  degp_s5 [2];
	logic [34:0]     val_s6 [2];

	// Stall chain from the output register backwards
	assign adv6 = !vld_s6 || pos_out.ready;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign rec_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= rec_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	// Unpack and compute per-lane arithmetic
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			int_in[l]  = rec_data[l*CW +: IW];
			frac_in[l] = rec_data[l*CW + IW +: FW];
			cnt_in[l]  = rec_data[l*CW + IW + FW +: NW];
			prod100[l] = (IW+26)'(int_in[l]) * (IW+26)'(RECIP_100);
			prodfs[l]  = (FW+24)'(frac_in[l]) *
				(FW+24)'(pow10(3'(FRACTION_DIGITS) - 3'(cnt_in[l])));
			rem100[l]  = 8'(int_s1[l] - IW'(q100_s1[l]) * IW'(100));
			prod15[l]  = 57'(min_s3[l][29:2]) * 57'(RECIP_15);
			rem15[l]   = 5'(x_s4[l] - 28'(q15_s4[l]) * 28'd15);
			sum[l]     = SUMW'(degp_s5[l]) + SUMW'(q15_s5[l]);
		end
	end

	// Stage 1: reciprocal estimate of degrees, scale fraction to full digits
	always_ff @(posedge clk) begin
		if (adv1) begin
			kind_s1 <= rec_data[2*CW +: 2];
			talk_s1 <= rec_data[2*CW + 2];
			for (int l = 0; l < 2; l++) begin
				neg_s1[l]  <= rec_data[l*CW + IW + FW + NW];
				int_s1[l]  <= int_in[l];
				q100_s1[l] <= prod100[l][IW+25:32];
				fs_s1[l]   <= FW'(prodfs[l]);
			end
		end
	end

	// Stage 2: correct degrees, split off whole minutes
	always_ff @(posedge clk) begin
		if (adv2) begin
			kind_s2 <= kind_s1;
			talk_s2 <= talk_s1;
			neg_s2  <= neg_s1;
			for (int l = 0; l < 2; l++) begin
				fs_s2[l] <= fs_s1[l];
				if (rem100[l] >= 8'd100) begin
					deg_s2[l] <= q100_s1[l] + QW'(1);
					mm_s2[l]  <= 7'(rem100[l] - 8'd100);
				end else begin
					deg_s2[l] <= q100_s1[l];
					mm_s2[l]  <= 7'(rem100[l]);
				end
			end
		end
	end

	// Stage 3: minutes in 1e-7 units, degrees in 1e-7 units
	always_ff @(posedge clk) begin
		if (adv3) begin
			kind_s3 <= kind_s2;
			talk_s3 <= talk_s2;
			neg_s3  <= neg_s2;
			for (int l = 0; l < 2; l++) begin
				min_s3[l]  <= 30'(mm_s2[l]) * 30'(E7) + 30'(fs_s2[l]) * 30'(SHIFT_SCALE);
				degp_s3[l] <= DPW'(deg_s2[l]) * DPW'(E7);
			end
		end
	end

	// Stage 4: divide minutes by four, then estimate the divide by fifteen
	always_ff @(posedge clk) begin
		if (adv4) begin
			kind_s4 <= kind_s3;
			talk_s4 <= talk_s3;
			neg_s4  <= neg_s3;
			for (int l = 0; l < 2; l++) begin
				x_s4[l]    <= min_s3[l][29:2];
				q15_s4[l]  <= prod15[l][55:32];
				degp_s4[l] <= degp_s3[l];
			end
		end
	end

	// Stage 5: correct the divide by fifteen
	always_ff @(posedge clk) begin
		if (adv5) begin
			kind_s5 <= kind_s4;
			talk_s5 <= talk_s4;
			neg_s5  <= neg_s4;
			for (int l = 0; l < 2; l++) begin
				degp_s5[l] <= degp_s4[l];
				q15_s5[l]  <= q15_s4[l] + 24'(rem15[l] >= 5'd15);
			end
		end
	end

	// Stage 6: add, apply sign, hold for the sink
	always_ff @(posedge clk) begin
		if (adv6) begin
			kind_s6 <= kind_s5;
			talk_s6 <= talk_s5;
			for (int l = 0; l < 2; l++) begin
				if (neg_s5[l]) begin
					val_s6[l] <= 35'(SUMW'(0) - sum[l]);
				end else begin
					val_s6[l] <= 35'(sum[l]);
				end
			end
		end
	end

	assign pos_out.valid         = vld_s6;
	assign pos_out.latitude_e7   = val_s6[0];
	assign pos_out.longitude_e7  = val_s6[1];
	assign pos_out.sentence_kind = kind_s6;
	assign pos_out.talker_kind   = talk_s6;

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && vld_s6 && !pos_out.ready |=> vld_s5 && vld_s6)
		else $error("pipeline stage dropped a transaction under backpressure");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pos_out.valid && !pos_out.ready |=> pos_out.valid &&
		$stable(pos_out.latitude_e7) && $stable(pos_out.longitude_e7) &&
		$stable(pos_out.sentence_kind) && $stable(pos_out.talker_kind))
		else $error("output transaction changed while waiting");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> rec_ready)
		else $error("input refused with an empty first stage");

endmodule

`default_nettype wire

// ----- sim/nmpp_checker.sv -----
`timescale 1ns / 100ps

// Watches the byte and position channels, runs a line parser of its own on
// every byte transaction and compares each position transaction with the
// oldest predicted record.
module nmpp_checker
	import nmpp_pkg::*;
#(
	parameter int unsigned FRACTION_DIGITS = 5,
	parameter int unsigned INTEGER_LIMIT = 99999
) (
	input  logic        clk,
	input  logic        arst_n,
	nmpp_byte_if        byte_ch,
	nmpp_pos_if         pos_ch,
	output int unsigned mismatches,
	output int unsigned fixes_pending
);

	localparam int unsigned MAX_FIELD = 15;
	localparam int unsigned REPORT_CAP = 200;

	typedef struct packed {
		logic signed [34:0] latitude;
		logic signed [34:0] longitude;
		kind_t              kind;
		talker_t            talker;
	} fix_t;

	fix_t expected_fixes[$];
	int unsigned fail_count = 0;

	// Line parser state, index 0 latitude, 1 longitude
	int unsigned          hdr_pos;
	logic [NUM_HDR-1:0]   hdr_alive;
	logic                 rejected;
	int unsigned          field_no;
	logic                 field_started;
	int unsigned          whole [2];
	int unsigned          frac [2];
	int unsigned          frac_len [2];
	logic                 dot_seen [2];
	logic                 halted [2];
	logic                 negative [2];

	task automatic report(input string msg);
		if (fail_count < REPORT_CAP)
			$display("mismatch at %0t: %s", $time, msg);
		fail_count++;
	endtask

	function automatic void clear_line();
		hdr_pos = 0;
		hdr_alive = '1;
		rejected = 1'b0;
		field_no = 0;
		field_started = 1'b0;
		for (int k = 0; k < 2; k++) begin
			whole[k] = 0;
			frac[k] = 0;
			frac_len[k] = 0;
			dot_seen[k] = 1'b0;
			halted[k] = 1'b0;
			negative[k] = 1'b0;
		end
	endfunction

	// Field holding the latitude number; direction, longitude and its direction follow
	function automatic int unsigned lat_field(input kind_t kind);
		case (kind)
			KIND_GGA: return 2;
			KIND_RMC: return 3;
			default:  return 1;
		endcase
	endfunction

	function automatic int unsigned first_candidate();
		for (int k = 0; k < NUM_HDR; k++)
			if (hdr_alive[k])
				return k;
		return 0;
	endfunction

	// Accumulate ddmm.mmmm, stopping at the first byte that does not fit
	function automatic void feed_digit(input int k, input logic [7:0] b);
		if (halted[k])
			return;
		if (b >= CH_0 && b <= CH_9) begin
			if (dot_seen[k]) begin
				if (frac_len[k] < FRACTION_DIGITS) begin
					frac[k] = frac[k] * 10 + (b - CH_0);
					frac_len[k]++;
				end
			end else begin
				whole[k] = whole[k] * 10 + (b - CH_0);
				if (whole[k] > INTEGER_LIMIT)
					whole[k] = INTEGER_LIMIT;
			end
		end else if (b == CH_DOT && !dot_seen[k]) begin
			dot_seen[k] = 1'b1;
		end else begin
			halted[k] = 1'b1;
		end
	endfunction

	// Degrees in 1e-7 units, truncated, then signed by the direction letter
	function automatic logic [34:0] to_e7(input int k);
		longint unsigned scale, part, minutes, deg;
		scale = 1;
		part = frac[k];
		for (int i = 0; i < FRACTION_DIGITS; i++)
			scale *= 10;
		for (int i = frac_len[k]; i < FRACTION_DIGITS; i++)
			part *= 10;
		minutes = 64'(whole[k] % 100) * scale + part;
		deg = 64'(whole[k] / 100) * 64'd10000000 + (minutes * 64'd10000000) / (scale * 60);
		if (negative[k])
			deg = 64'd0 - deg;
		return deg[34:0];
	endfunction

	task automatic parse_byte(input logic [7:0] b);
		logic [NUM_HDR-1:0] m;
		int unsigned idx, base;
		fix_t rec;
		if (b == CH_LF) begin
			// End of line: emit a record if the longitude direction was reached
			if (!rejected && hdr_pos == HDR_LEN) begin
				idx = first_candidate();
				base = lat_field(kind_t'(idx % 3));
				if (field_no > base + 3 || (field_no == base + 3 && field_started)) begin
					rec.latitude = to_e7(0);
					rec.longitude = to_e7(1);
					rec.kind = kind_t'(idx % 3);
					rec.talker = talker_t'(idx / 3);
					expected_fixes.insert(expected_fixes.size(), rec);
				end
			end
			clear_line();
		end else if (!rejected) begin
			if (hdr_pos < HDR_LEN) begin
				// Narrow the header candidates
				m = '0;
				for (int k = 0; k < NUM_HDR; k++)
					m[k] = (HDR_TEXT[k][hdr_pos] == b);
				hdr_alive &= m;
				hdr_pos++;
				if (hdr_alive == '0)
					rejected = 1'b1;
				field_started = 1'b1;
			end else if (b == CH_COMMA) begin
				if (field_no < MAX_FIELD)
					field_no++;
				field_started = 1'b0;
			end else begin
				base = lat_field(kind_t'(first_candidate() % 3));
				for (int k = 0; k < 2; k++) begin
					if (field_no == base + 2 * k)
						feed_digit(k, b);
					else if (field_no == base + 2 * k + 1 && !field_started)
						negative[k] = (b == CH_S || b == CH_W);
				end
				field_started = 1'b1;
			end
		end
	endtask

	// Predict on byte transactions, compare on position transactions
	always @(posedge clk) begin
		fix_t want;
		if (!arst_n) begin
			clear_line();
			expected_fixes.delete();
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				parse_byte(byte_ch.data_byte);
			if (pos_ch.valid && pos_ch.ready) begin
				if (expected_fixes.size() == 0) begin
					report($sformatf("record with none expected: lat %0d lon %0d kind %0d talker %0d",
						pos_ch.latitude_e7, pos_ch.longitude_e7, pos_ch.sentence_kind,
						pos_ch.talker_kind));
				end else begin
					want = expected_fixes.pop_front();
					if (pos_ch.latitude_e7 !== want.latitude)
						report($sformatf("latitude_e7 %0d, expected %0d",
							pos_ch.latitude_e7, want.latitude));
					if (pos_ch.longitude_e7 !== want.longitude)
						report($sformatf("longitude_e7 %0d, expected %0d",
							pos_ch.longitude_e7, want.longitude));
					if (pos_ch.sentence_kind !== want.kind)
						report($sformatf("sentence_kind %0d, expected %0d",
							pos_ch.sentence_kind, want.kind));
					if (pos_ch.talker_kind !== want.talker)
						report($sformatf("talker_kind %0d, expected %0d",
							pos_ch.talker_kind, want.talker));
				end
			end
		end
		mismatches <= fail_count;
		fixes_pending <= expected_fixes.size();
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import nmpp_pkg::*;

	localparam int unsigned FRACTION_DIGITS = 5;
	localparam int unsigned INTEGER_LIMIT = 99999;
	localparam int unsigned BYTE_TARGET = 2000;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] COMPASS [4] = '{"N", "S", "E", "W"};

	logic clk;
	logic arst_n;
	int unsigned mismatches;
	int unsigned fixes_pending;
	int unsigned cycle_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned sink_stall = 0;
	logic steady_source = 1'b0;
	logic steady_sink = 1'b0;
	logic [7:0] line_buf[$];

	nmpp_byte_if byte_ch();
	nmpp_pos_if pos_ch();

	nmea_position_parser #(
		.FRACTION_DIGITS(FRACTION_DIGITS),
		.INTEGER_LIMIT(INTEGER_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_ch),
		.pos_out(pos_ch)
	);

	nmpp_checker #(
		.FRACTION_DIGITS(FRACTION_DIGITS),
		.INTEGER_LIMIT(INTEGER_LIMIT)
	) u_fix_check (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.pos_ch(pos_ch),
		.mismatches(mismatches),
		.fixes_pending(fixes_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then long
	function automatic int unsigned gap_cycles();
		int unsigned r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Stall the position channel at random, with calm stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			pos_ch.ready <= 1'b0;
			sink_stall <= 0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				steady_sink <= ~steady_sink;
			if (sink_stall != 0) begin
				pos_ch.ready <= 1'b0;
				sink_stall <= sink_stall - 1;
			end else if (!steady_sink && $urandom_range(0, 3) == 0) begin
				pos_ch.ready <= 1'b0;
				sink_stall <= gap_cycles();
			end else begin
				pos_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned idle;
		idle = steady_source ? 0 : gap_cycles();
		if (idle != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_line();
		if ($urandom_range(0, 7) == 0)
			steady_source = ~steady_source;
		foreach (line_buf[i])
			send_byte(line_buf[i]);
		line_buf.delete();
	endtask

	// Append one byte to the line under construction
	function automatic void put_byte(input logic [7:0] b);
		line_buf.insert(line_buf.size(), b);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	function automatic void add_digits(input int unsigned n);
		for (int i = 0; i < n; i++)
			put_byte(CH_0 + 8'($urandom_range(0, 9)));
	endfunction

	// ddmm.mmmm with random length, sometimes empty, overlong or spoilt
	function automatic void add_number();
		int unsigned mode;
		mode = $urandom_range(0, 9);
		if (mode == 0)
			return;
		if (mode == 1)
			put_byte(8'($urandom_range(8'h21, 8'h7E)));
		add_digits(mode == 2 ? $urandom_range(6, 10) : $urandom_range(0, 5));
		if ($urandom_range(0, 4) != 0) begin
			put_byte(CH_DOT);
			add_digits($urandom_range(0, 9));
		end
		if ($urandom_range(0, 7) == 0)
			put_byte(8'($urandom_range(8'h20, 8'h7E)));
	endfunction

	function automatic void add_direction();
		case ($urandom_range(0, 9))
			0: ;
			1: put_byte(8'($urandom_range(8'h21, 8'h7E)));
			default: begin
				put_byte(COMPASS[$urandom_range(0, 3)]);
				if ($urandom_range(0, 5) == 0)
					put_byte(8'($urandom_range(8'h30, 8'h5A)));
			end
		endcase
	endfunction

	// Sentence with a valid header and random, sometimes short or spoilt fields, no line end
	function automatic void build_sentence();
		int unsigned hdr, base, nf, n;
		hdr = $urandom_range(0, NUM_HDR - 1);
		for (int i = 0; i < HDR_LEN; i++)
			put_byte(HDR_TEXT[hdr][i]);
		case (HDR_KIND[hdr])
			KIND_GGA: base = 2;
			KIND_RMC: base = 3;
			default:  base = 1;
		endcase
		nf = base + 3;
		case ($urandom_range(0, 7))
			0: nf = $urandom_range(0, base + 3);
			1, 2: nf = nf + $urandom_range(1, 14);
			default: ;
		endcase
		for (int f = 1; f <= nf; f++) begin
			put_byte(CH_COMMA);
			if (f == base || f == base + 2) begin
				add_number();
			end else if (f == base + 1 || f == base + 3) begin
				add_direction();
			end else begin
				n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++)
					put_byte(8'($urandom_range(8'h30, 8'h5A)));
			end
		end
		if ($urandom_range(0, 3) == 0)
			add_text($sformatf("*%02X", $urandom_range(0, 255)));
	endfunction

	initial begin
		string directed[$];
		int unsigned n;

		directed = '{
			"\n",
			"$GPGGA,1,4807.038,N,01131.000,E,1\n",
			"$GNRMC,0,A,9999999.99999999,S,99999.999,W\n",
			"$GPGLL,12.3.4,W,-5,S\r\n",
			"$GNGLL,5\r,N,.5,E\n",
			"$GPRMC,1,A,2,N,3\n",
			"$GNGGA,,,,,,\n",
			"$GPGLL,,,,\n",
			"$GPGG\n",
			"$GP,GA,1\n",
			"$GPXGA,1,N,2,E\n",
			"$GNGLL,1,N,2,E,,,,,,,,,,,,,,,,,,\n",
			"$GPGLL,1,SW,2,WEST\n",
			"$GNGGA,x,0000.00000,E,0000.0,N\n"
		};
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines: every header, extremes and malformed cases
		foreach (directed[i]) begin
			add_text(directed[i]);
			send_line();
		end
		line_buf = '{8'h00, 8'hFF, 8'h80, CH_LF};
		send_line();

		// Random lines, mostly well-formed
		while (bytes_sent < BYTE_TARGET) begin
			case ($urandom_range(0, 9))
				0: begin
					n = $urandom_range(1, 30);
					for (int i = 0; i < n; i++)
						put_byte(8'($urandom_range(0, 255)));
				end
				1: begin
					build_sentence();
					line_buf[$urandom_range(0, HDR_LEN - 1)] = 8'($urandom_range(0, 255));
				end
				2: begin
					build_sentence();
					n = $urandom_range(0, HDR_LEN - 1);
					while (line_buf.size() > n)
						void'(line_buf.pop_back());
				end
				default: build_sentence();
			endcase
			if ($urandom_range(0, 2) != 0)
				put_byte(CH_CR);
			put_byte(CH_LF);
			send_line();
		end
		byte_ch.valid <= 1'b0;

		// Drain outstanding records once the last prediction has settled
		@(posedge clk);
		while (fixes_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && fixes_pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- nmea_position_parser.f -----
rtl/nmpp_pkg.sv
rtl/nmpp_if.sv
rtl/nmpp_front.sv
rtl/nmpp_fifo.sv
rtl/nmpp_conv.sv
rtl/nmea_position_parser.sv
sim/nmpp_checker.sv
sim/tb.sv
